// ===== rtl/core/vlbs_pkg.sv =====
`default_nettype none

package vlbs_pkg;

    localparam int CAPACITY_DEF    = 1024;
    localparam int MAX_RECORDS_DEF = 64;
    localparam int MAX_LENGTH_DEF  = 64;

    localparam int LEN_W  = 7;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 2;

    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [STAT_W-1:0] t_status;

    localparam logic    MODE_PUSH = 1'b0;
    localparam logic    MODE_POP  = 1'b1;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_EMPTY    = 2'd1;
    localparam t_status ST_OVERFLOW = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/variable_length_byte_stack_unit.sv =====
`default_nettype none

// Last-in first-out stack of byte records. A push item carries one record byte
// (tdata) with tlast on its final byte; that final byte gives one status item
// (ok, or overflow when the record exceeded the byte store, the record count
// or the maximum length and was dropped). A pop item (tuser = 1) returns the
// top record's bytes in their original order, tlast on the last, or a single
// empty status item. The byte store and the length stack are synchronous RAMs
// with one write port and one registered read port. A push byte is taken in
// the idle state; the final byte moves to the emit state, which sends the
// status item. A pop reads the length stack, then reads the byte store one
// byte per read, each read registered before its byte is sent, and output
// stalls hold it. Nothing is accepted while a request is in progress.

module variable_length_byte_stack_unit
    import vlbs_pkg::*;
#(
    parameter int CAPACITY    = vlbs_pkg::CAPACITY_DEF,
    parameter int MAX_RECORDS = vlbs_pkg::MAX_RECORDS_DEF,
    parameter int MAX_LENGTH  = vlbs_pkg::MAX_LENGTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,  // [7:0] data_byte
    input  wire  [0:0]  i_s_axis_tuser,  // [0] mode
    input  wire         i_s_axis_tlast,  // item_last
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // [7:0] out_byte
    output logic [1:0]  o_m_axis_tuser,  // [1:0] status
    output logic        o_m_axis_tlast   // out_last
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int UW  = $clog2(CAPACITY + 1);
    localparam int RAW = $clog2(MAX_RECORDS);
    localparam int RCW = $clog2(MAX_RECORDS + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EMIT    = 3'd1;
    localparam logic [2:0] S_POP_LEN = 3'd2;
    localparam logic [2:0] S_POP_RD  = 3'd3;
    localparam logic [2:0] S_POP_OUT = 3'd4;

    logic [2:0]     r_state, n_state;
    logic [UW-1:0]  r_bytes_used, n_bytes_used;
    logic [RCW-1:0] r_record_count, n_record_count;
    t_len           r_pend_len, n_pend_len;
    logic           r_pend_ovf, n_pend_ovf;
    logic           r_out_valid, n_out_valid;

    t_byte          r_out_byte, n_out_byte;
    logic           r_out_last, n_out_last;
    t_status        r_out_status, n_out_status;
    t_status        r_res_status, n_res_status;
    logic [AW-1:0]  r_rd_addr, n_rd_addr;
    t_len           r_remain, n_remain;
    logic [UW-1:0]  r_start, n_start;

    logic           in_acc;
    logic           out_free;
    logic [UW-1:0]  pos;
    logic           push_ovf;
    t_len           push_len;
    logic           commit;
    logic           byte_we;
    logic           len_we;
    t_byte          rd_byte;
    t_len           rd_len;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    assign pos      = r_bytes_used + UW'(r_pend_len);
    assign push_ovf = r_pend_ovf || (r_pend_len >= LEN_W'(MAX_LENGTH))
                      || (pos >= UW'(CAPACITY));
    assign push_len = push_ovf ? r_pend_len : r_pend_len + 1'b1;
    assign commit   = !push_ovf && (r_record_count < RCW'(MAX_RECORDS))
                      && (push_len != '0);

    assign byte_we  = in_acc && (i_s_axis_tuser[0] == MODE_PUSH) && !push_ovf;
    assign len_we   = in_acc && (i_s_axis_tuser[0] == MODE_PUSH) && i_s_axis_tlast
                      && commit;

    vlbs_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (BYTE_W)
    ) u_byte_store (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr (pos[AW-1:0]),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (r_rd_addr),
        .o_rdata (rd_byte)
    );

    vlbs_ram #(
        .DEPTH (MAX_RECORDS),
        .WIDTH (LEN_W)
    ) u_len_stack (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (r_record_count[RAW-1:0]),
        .i_wdata (push_len),
        .i_raddr (RAW'(r_record_count - 1'b1)),
        .o_rdata (rd_len)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    always_comb begin
        n_state        = r_state;
        n_bytes_used   = r_bytes_used;
        n_record_count = r_record_count;
        n_pend_len     = r_pend_len;
        n_pend_ovf     = r_pend_ovf;
        n_out_valid    = r_out_valid && !i_m_axis_tready;
        n_out_byte     = r_out_byte;
        n_out_last     = r_out_last;
        n_out_status   = r_out_status;
        n_res_status   = r_res_status;
        n_rd_addr      = r_rd_addr;
        n_remain       = r_remain;
        n_start        = r_start;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_s_axis_tuser[0] == MODE_POP) begin
                        n_pend_len = '0;
                        n_pend_ovf = 1'b0;
                        if (r_record_count == '0) begin
                            n_res_status = ST_EMPTY;
                            n_state      = S_EMIT;
                        end else begin
                            n_state = S_POP_LEN;
                        end
                    end else if (i_s_axis_tlast) begin
                        n_pend_len = '0;
                        n_pend_ovf = 1'b0;
                        if (commit) begin
                            n_record_count = r_record_count + 1'b1;
                            n_bytes_used   = r_bytes_used + UW'(push_len);
                            n_res_status   = ST_OK;
                        end else begin
                            n_res_status = ST_OVERFLOW;
                        end
                        n_state = S_EMIT;
                    end else begin
                        n_pend_len = push_len;
                        n_pend_ovf = push_ovf;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = '0;
                    n_out_last   = 1'b1;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            S_POP_LEN: begin
                n_start   = r_bytes_used - UW'(rd_len);
                n_rd_addr = AW'(r_bytes_used - UW'(rd_len));
                n_remain  = rd_len;
                n_state   = S_POP_RD;
            end
            S_POP_RD: begin
                n_state = S_POP_OUT;
            end
            S_POP_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = rd_byte;
                    n_out_last   = (r_remain == LEN_W'(1));
                    n_out_status = ST_OK;
                    if (r_remain == LEN_W'(1)) begin
                        n_record_count = r_record_count - 1'b1;
                        n_bytes_used   = r_start;
                        n_state        = S_IDLE;
                    end else begin
                        n_rd_addr = r_rd_addr + 1'b1;
                        n_remain  = r_remain - 1'b1;
                        n_state   = S_POP_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_bytes_used   <= '0;
            r_record_count <= '0;
            r_pend_len     <= '0;
            r_pend_ovf     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_bytes_used   <= n_bytes_used;
            r_record_count <= n_record_count;
            r_pend_len     <= n_pend_len;
            r_pend_ovf     <= n_pend_ovf;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
        r_res_status <= n_res_status;
        r_rd_addr    <= n_rd_addr;
        r_remain     <= n_remain;
        r_start      <= n_start;
    end

endmodule

`default_nettype wire

// ===== rtl/core/vlbs_ram.sv =====
`default_nettype none

module vlbs_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== verif/variable_length_byte_stack_unit_tb.sv =====
`default_nettype none

module variable_length_byte_stack_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vlbs_pkg::*;

    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        t_byte   data;
        logic    last;
        t_status status;
    } stack_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = '0;
    logic [0:0]  s_user = '0;
    logic        s_last = 1'b0;
    logic        m_ready = 1'b0;
    wire         s_ready;
    wire         m_valid;
    wire  [7:0]  m_data;
    wire  [1:0]  m_user;
    wire         m_last;

    // shadow copy of the stack
    t_byte shadow_bytes [CAPACITY_DEF];
    t_len  shadow_lens [MAX_RECORDS_DEF];
    int    shadow_used = 0;
    int    shadow_count = 0;
    int    open_len = 0;
    bit    open_overflow = 1'b0;

    stack_out_t due_items[$];

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    int n_pushes = 0;
    int n_pops = 0;
    int n_results = 0;
    int n_ok = 0;
    int n_empty = 0;
    int n_overflow = 0;
    int mismatch_count = 0;

    variable_length_byte_stack_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [7:0] data_byte
        .i_s_axis_tuser  (s_user),   // [0] mode
        .i_s_axis_tlast  (s_last),   // item_last
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // [7:0] out_byte
        .o_m_axis_tuser  (m_user),   // [1:0] status
        .o_m_axis_tlast  (m_last)    // out_last
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    always @(posedge clk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void stack_apply(input logic op, input t_byte b, input logic is_final);
        stack_out_t r;
        int         n;
        int         start;
        int         pos;
        r = '0;
        r.last = 1'b1;
        if (op == MODE_POP) begin
            open_len = 0;
            open_overflow = 1'b0;
            if (shadow_count == 0) begin
                r.status = ST_EMPTY;
                due_items.push_back(r);
            end else begin
                n = shadow_lens[shadow_count - 1];
                start = shadow_used - n;
                for (int k = 0; k < n; k++) begin
                    r.data = shadow_bytes[start + k];
                    r.last = (k == n - 1);
                    r.status = ST_OK;
                    due_items.push_back(r);
                end
                shadow_count--;
                shadow_used = start;
            end
        end else begin
            if (!open_overflow) begin
                pos = shadow_used + open_len;
                if (open_len >= MAX_LENGTH_DEF || pos >= CAPACITY_DEF) begin
                    open_overflow = 1'b1;
                end else begin
                    shadow_bytes[pos] = b;
                    open_len++;
                end
            end
            if (is_final) begin
                if (open_overflow || shadow_count >= MAX_RECORDS_DEF || open_len == 0) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    shadow_lens[shadow_count] = t_len'(open_len);
                    shadow_count++;
                    shadow_used += open_len;
                    r.status = ST_OK;
                end
                due_items.push_back(r);
                open_len = 0;
                open_overflow = 1'b0;
            end
        end
    endfunction

    always @(posedge clk) begin
        stack_out_t want;
        if (rst_n && m_valid && m_ready) begin
            n_results++;
            if (due_items.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected item: byte %02h last %0d status %0d",
                             m_data, m_last, m_user);
                end
            end else begin
                want = due_items.pop_front();
                if (m_data !== want.data || m_last !== want.last
                    || m_user !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected byte %02h last %0d status %0d,",
                                 want.data, want.last, want.status,
                                 " got byte %02h last %0d status %0d",
                                 m_data, m_last, m_user);
                    end
                end
                if (want.last) begin
                    case (want.status)
                        ST_OK:       n_ok++;
                        ST_EMPTY:    n_empty++;
                        ST_OVERFLOW: n_overflow++;
                        default: ;
                    endcase
                end
            end
        end
    end

    task automatic send_item(input logic op, input t_byte b, input logic is_final);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= b;
        s_last  <= is_final;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        stack_apply(op, b, is_final);
        items_sent++;
        if (op == MODE_POP) n_pops++;
        else n_pushes++;
    endtask

    task automatic send_pop();
        send_item(MODE_POP, t_byte'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic push_record(input int n);
        for (int k = 0; k < n; k++) begin
            send_item(MODE_PUSH, t_byte'($urandom_range(255)), k == n - 1);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (due_items.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(input int sender_pct, input int recv_pct);
        sender_idle_pct = sender_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic test_empty_pop();
        send_pop();
    endtask

    task automatic test_lifo_order();
        send_item(MODE_PUSH, 8'hFF, 1'b1);
        send_pop();
        send_item(MODE_PUSH, 8'h00, 1'b0);
        send_item(MODE_PUSH, 8'hA5, 1'b1);
        send_item(MODE_PUSH, 8'h5A, 1'b1);
        send_pop();
        send_pop();
        // unfinished record is thrown away by a pop
        send_item(MODE_PUSH, 8'hC3, 1'b0);
        send_item(MODE_PUSH, 8'h3C, 1'b0);
        send_item(MODE_PUSH, 8'h81, 1'b0);
        send_pop();
        send_pop();
    endtask

    task automatic test_length_limit();
        push_record(2);
        push_record(MAX_LENGTH_DEF + 1);
        send_pop();
        send_pop();
    endtask

    task automatic test_record_limit();
        for (int k = 0; k < MAX_RECORDS_DEF; k++) push_record(1);
        push_record(1);
        push_record(3);
        for (int k = 0; k <= MAX_RECORDS_DEF; k++) send_pop();
    endtask

    task automatic test_random(input int n_items);
        int first;
        int pick;
        int len;
        first = items_sent;
        while (items_sent - first < n_items) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                len = $urandom_range(99);
                if (len < 84) push_record($urandom_range(1, 8));
                else if (len < 95) push_record($urandom_range(9, MAX_LENGTH_DEF));
                else push_record($urandom_range(MAX_LENGTH_DEF + 1, MAX_LENGTH_DEF + 3));
            end else if (pick < 90) begin
                send_pop();
            end else begin
                // broken record cut short by a pop
                for (int k = $urandom_range(1, 4); k > 0; k--) begin
                    send_item(MODE_PUSH, t_byte'($urandom_range(255)), 1'b0);
                end
                send_pop();
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(0, 0);
        test_empty_pop();
        test_lifo_order();
        test_length_limit();
        wait_idle();

        set_idling(17, 17);
        test_record_limit();
        wait_idle();

        set_idling(0, 0);
        test_random(12);
        wait_idle();
        set_idling(80, 0);
        test_random(12);
        wait_idle();
        set_idling(0, 80);
        test_random(12);
        wait_idle();
        set_idling(17, 17);
        test_random(12);
        wait_idle();

        $display("covered %0d pushes and %0d pops, %0d output items checked",
                 n_pushes, n_pops, n_results);
        $display("request outcomes: %0d ok, %0d empty, %0d overflow, %0d mismatches",
                 n_ok, n_empty, n_overflow, mismatch_count);
        if (mismatch_count == 0 && due_items.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/vlbs_pkg.sv
rtl/core/vlbs_ram.sv
rtl/core/variable_length_byte_stack_unit.sv
verif/variable_length_byte_stack_unit_tb.sv
